[src/rlfp_pkg.sv]
package rlfp_pkg;

  // Line buffer size; one byte of it is reserved, so LineBuffer-1 bytes are kept
  localparam int LineBuffer = 128;
  localparam int KeptW      = $clog2(LineBuffer);
  localparam logic [KeptW-1:0] KeepMax = KeptW'(LineBuffer - 1);

  // Fields counted per line, saturating
  localparam logic [2:0] FieldMax   = 3'd5;
  localparam logic [2:0] FieldVal0  = 3'd2;
  localparam logic [2:0] FieldVal1  = 3'd3;
  localparam logic [2:0] FieldVal2  = 3'd4;

  // Magnitude cap: 2^31
  localparam logic [31:0] MagCap    = 32'h8000_0000;
  localparam logic [31:0] PosMax    = 32'h7FFF_FFFF;

  // Character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  // Token phase: between tokens, in prefix, after sign, in digits
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_SIGN   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic signed [31:0] third_value;
    logic signed [31:0] second_value;
    logic signed [31:0] first_value;
    status_t            status;
  } result_t;

  // Pipeline control from the parser: item consumed, result loaded
  typedef struct packed {
    logic step;
    logic load;
  } ctl_t;

endpackage

[src/rlfp_in_reg.sv]
module rlfp_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlfp_pkg::item_t     in_item,
  input  rlfp_pkg::ctl_t      ctl,
  output logic                item_valid,
  output rlfp_pkg::item_t     item
);
  import rlfp_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Accept when empty or when the held request is consumed this cycle
  assign in_ready = !valid_r || ctl.step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (ctl.step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload; no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[src/rlfp_parser.sv]
module rlfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  rlfp_pkg::item_t     item,
  input  logic                out_free,
  output rlfp_pkg::ctl_t      ctl,
  output rlfp_pkg::result_t   result
);
  import rlfp_pkg::*;

  typedef struct packed {
    logic [KeptW-1:0] kept;
    logic [2:0]       field;
    logic             text_ended;
    phase_t           phase;
    logic             neg;
    logic             has_digit;
    logic             bad;
    logic [31:0]      mag;
    logic [31:0]      cap0;
    logic [31:0]      cap1;
    logic [31:0]      cap2;
  } state_t;

  state_t  st_r;
  state_t  st_nxt;
  state_t  work;
  state_t  fin;
  logic    is_end;
  logic    emit;
  logic    step;
  result_t res;

  function automatic logic is_value_field(input logic [2:0] field);
    return (field >= FieldVal0) && (field <= FieldVal2);
  endfunction

  function automatic state_t clear_token(input state_t s);
    state_t t;
    t           = s;
    t.phase     = PH_IDLE;
    t.neg       = 1'b0;
    t.has_digit = 1'b0;
    t.mag       = '0;
    return t;
  endfunction

  // Close the current token: store a value field, count the field
  function automatic state_t finish_token(input state_t s);
    state_t      t;
    logic [31:0] v;
    t = s;
    if (s.phase != PH_IDLE) begin
      if (is_value_field(s.field)) begin
        if (!s.has_digit) begin
          t.bad = 1'b1;
        end else begin
          if (s.neg) begin
            v = 32'd0 - s.mag;
          end else begin
            v = s.mag[31] ? PosMax : s.mag;
          end
          case (s.field)
            FieldVal0: t.cap0 = v;
            FieldVal1: t.cap1 = v;
            FieldVal2: t.cap2 = v;
            default:   t.cap0 = s.cap0;
          endcase
        end
      end
      if (s.field < FieldMax) begin
        t.field = s.field + 3'd1;
      end
      t = clear_token(t);
    end
    return t;
  endfunction

  // Advance the token state for one non-NUL byte
  function automatic state_t parse_char(input state_t s, input logic [7:0] c);
    state_t      t;
    logic [35:0] m;
    t = s;
    m = {1'b0, s.mag, 3'b000} + {3'b000, s.mag, 1'b0} + {28'd0, c - Ch0};
    if (c == ChSpace || c == ChTab || c == ChComma) begin
      t = finish_token(s);
    end else if (!is_value_field(s.field)) begin
      t.phase = PH_PREFIX;
    end else begin
      if (s.phase == PH_IDLE) begin
        t.phase = PH_PREFIX;
      end
      if (c >= Ch0 && c <= Ch9) begin
        t.mag       = (m > {4'd0, MagCap}) ? MagCap : m[31:0];
        t.has_digit = 1'b1;
        t.phase     = PH_DIGITS;
      end else if (t.phase == PH_PREFIX && (c == ChVt || c == ChFf)) begin
        t.phase = PH_PREFIX;
      end else if (t.phase == PH_PREFIX && (c == ChPlus || c == ChMinus)) begin
        t.neg   = (c == ChMinus);
        t.phase = PH_SIGN;
      end else begin
        t.bad   = 1'b1;
        t.phase = PH_DIGITS;
      end
    end
    return t;
  endfunction

  // Next state and result for the held request
  always_comb begin
    work   = st_r;
    fin    = finish_token(st_r);
    emit   = 1'b0;
    res    = '0;
    is_end = (item.kind == KIND_TIMEOUT) || (item.rx_byte == ChCr) ||
             (item.rx_byte == ChLf);
    if (is_end) begin
      if (st_r.kept != '0) begin
        emit = 1'b1;
        if (fin.field < FieldMax) begin
          res.status = ST_FEW;
        end else if (fin.bad) begin
          res.status = ST_BAD;
        end else begin
          res.status       = ST_OK;
          res.first_value  = fin.cap0;
          res.second_value = fin.cap1;
          res.third_value  = fin.cap2;
        end
      end
      work = '0;
    end else if (st_r.kept < KeepMax) begin
      work.kept = st_r.kept + KeptW'(1);
      if (!st_r.text_ended) begin
        if (item.rx_byte == ChNul) begin
          work            = fin;
          work.kept       = st_r.kept + KeptW'(1);
          work.text_ended = 1'b1;
        end else begin
          work      = parse_char(st_r, item.rx_byte);
          work.kept = st_r.kept + KeptW'(1);
        end
      end
    end
  end

  // Consume the request unless its result has nowhere to go
  assign step   = item_valid && (!emit || out_free);
  assign st_nxt = step ? work : st_r;

  assign ctl.step = step;
  assign ctl.load = step && emit;
  assign result   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_field_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.field <= FieldMax)
    else $error("field count above saturation");

  a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.kept <= KeepMax)
    else $error("kept byte count above buffer limit");

  a_emit_content: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> st_r.kept != '0)
    else $error("result from a line without content");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (st_r.kept == '0 && st_r.field == '0 && !st_r.bad))
    else $error("line state not cleared after result");

  a_idle_token: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IDLE |-> (st_r.mag == '0 && !st_r.neg && !st_r.has_digit))
    else $error("token state left over between tokens");
`endif

endmodule

[src/rlfp_out_reg.sv]
module rlfp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  rlfp_pkg::ctl_t      ctl,
  input  rlfp_pkg::result_t   result,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output rlfp_pkg::result_t   out_result
);
  import rlfp_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // Slot is free when empty or being drained this cycle
  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

[src/reply_line_field_parser_top.sv]
// Channel  Ports               Payload
// in       in_tvalid/in_tready  tdata[7:0] rx_byte; tuser[0] kind
// out      out_tvalid/out_tready tdata: status, first, second, third value
//
// One request per cycle sustained while no line-ending request waits on a full result
// register; every byte is parsed combinationally between the input and result registers.
// A line end is held in the input register, then its result in the result register.
// Synchronous active-low reset clears both valid flags and the line state.
// in_tready drops only when a line-ending request waits on a full result
// register that is not being taken; bytes that do not end a line never wait.
module reply_line_field_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,    // [7:0] rx_byte
  input  logic [0:0]    in_tuser,    // [0] kind
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata    // [1:0] status, [33:2] first_value,
                                     // [65:34] second_value, [97:66] third_value
);
  import rlfp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  ctl_t    ctl;
  result_t result;
  result_t out_result;
  logic    out_free;

  assign in_item.kind    = kind_t'(in_tuser[0]);
  assign in_item.rx_byte = in_tdata;

  rlfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  rlfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .ctl        (ctl),
    .result     (result)
  );

  rlfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack result fields, lowest field first, zero fill to whole bytes
  assign out_tdata = {6'd0, out_result};

endmodule
